// File: hw/rtl/edge_count_beep_sequencer_assert.svh
// ----------------------------------------------------------------------------
// edge_count_beep_sequencer assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef EDGE_COUNT_BEEP_SEQUENCER_ASSERT_SVH
`define EDGE_COUNT_BEEP_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define ECBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ECBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ecbs_pkg.sv
// ----------------------------------------------------------------------------
// ecbs_pkg
// types and constants shared by the beep sequencer modules
// ----------------------------------------------------------------------------
package ecbs_pkg;

    localparam int unsigned FLAG_W  = 3;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;

    localparam logic [CFG_W-1:0]   TIME_RESET = 16'd400;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;
    localparam logic [1:0]         BEEPS_RISE = 2'd1;
    localparam logic [1:0]         BEEPS_FALL = 2'd2;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_ON_TIME  = 1'b0,
        REG_OFF_TIME = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] on_time_ms;
        logic [CFG_W-1:0] off_time_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [FLAG_W-1:0] flags;   // bit0 catch, bit1 outpost, bit2 engineer
    } item_t;

    typedef struct packed {
        logic               buzzer_on;
        logic [COUNT_W-1:0] pending_beeps;
    } result_t;

endpackage

// File: hw/rtl/ecbs_regs.sv
// ----------------------------------------------------------------------------
// ecbs_regs
// apb register file holding the beep on and off times
// ----------------------------------------------------------------------------
module ecbs_regs
    import ecbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t wr_idx;

    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_time_ms  <= TIME_RESET;
            cfg_reg.off_time_ms <= TIME_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_ON_TIME:  cfg_reg.on_time_ms  <= pwdata[CFG_W-1:0];
                REG_OFF_TIME: cfg_reg.off_time_ms <= pwdata[CFG_W-1:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_idx)
            REG_ON_TIME:  prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_reg.on_time_ms};
            REG_OFF_TIME: prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_reg.off_time_ms};
            default:      prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/ecbs_core.sv
// ----------------------------------------------------------------------------
// ecbs_core
// sequencer state and its combinational update for one item
// ----------------------------------------------------------------------------
module ecbs_core
    import ecbs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

`include "edge_count_beep_sequencer_assert.svh"

    logic               primed_reg;
    logic [FLAG_W-1:0]  last_flags_reg;
    logic [COUNT_W-1:0] beep_count_reg;
    logic               sounding_reg;
    logic [TIME_W-1:0]  stage_start_reg;

    logic               primed_next;
    logic [FLAG_W-1:0]  last_flags_next;
    logic [COUNT_W-1:0] beep_count_next;
    logic               sounding_next;
    logic [TIME_W-1:0]  stage_start_next;

    logic [FLAG_W-1:0]  flag_diff;
    logic [2:0]         add_beeps;
    logic [COUNT_W:0]   count_sum;
    logic [COUNT_W-1:0] count_queued;
    logic [TIME_W-1:0]  elapsed;
    logic               on_done;
    logic               off_done;

    assign flag_diff = item.flags ^ last_flags_reg;
    assign elapsed   = item.now_ms - stage_start_reg;
    assign on_done   = elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.on_time_ms};
    assign off_done  = elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.off_time_ms};

    always_comb
    begin
        add_beeps = '0;
        for (int b = 0; b < FLAG_W; b++)
        begin
            if (flag_diff[b])
            begin
                add_beeps = add_beeps + {1'b0, (item.flags[b] ? BEEPS_RISE : BEEPS_FALL)};
            end
        end
        count_sum    = {1'b0, beep_count_reg} + {{(COUNT_W-2){1'b0}}, add_beeps};
        count_queued = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];

        primed_next      = primed_reg;
        last_flags_next  = item.flags;
        beep_count_next  = beep_count_reg;
        sounding_next    = sounding_reg;
        stage_start_next = stage_start_reg;

        if (!primed_reg)
        begin
            primed_next = 1'b1;
        end
        else
        begin
            beep_count_next = count_queued;
            if (sounding_reg)
            begin
                if (on_done)
                begin
                    sounding_next    = 1'b0;
                    stage_start_next = item.now_ms;
                    if (count_queued != '0)
                    begin
                        beep_count_next = count_queued - {{(COUNT_W-1){1'b0}}, 1'b1};
                    end
                end
            end
            else if (count_queued != '0 && off_done)
            begin
                sounding_next    = 1'b1;
                stage_start_next = item.now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg      <= 1'b0;
            last_flags_reg  <= '0;
            beep_count_reg  <= '0;
            sounding_reg    <= 1'b0;
            stage_start_reg <= '0;
        end
        else if (step)
        begin
            primed_reg      <= primed_next;
            last_flags_reg  <= last_flags_next;
            beep_count_reg  <= beep_count_next;
            sounding_reg    <= sounding_next;
            stage_start_reg <= stage_start_next;
        end
    end

    assign result.buzzer_on     = sounding_next;
    assign result.pending_beeps = beep_count_next;

    // a beep only starts with something queued
    `ECBS_ASSERT_NOW(a_start_needs_beep,
        $rose(sounding_reg), beep_count_reg != '0,
        "beep started with empty queue")
    // the queue only shrinks when a beep ends
    `ECBS_ASSERT_NOW(a_drop_on_end,
        beep_count_reg < $past(beep_count_reg), $fell(sounding_reg),
        "pending count dropped without a beep ending")
    // stage timestamp moves only with a stage change
    `ECBS_ASSERT_NOW(a_stage_with_change,
        !$stable(stage_start_reg), !$stable(sounding_reg),
        "stage start moved without a stage change")
    // nothing moves before the first item has primed the flags
    `ECBS_ASSERT_NEXT(a_prime_quiet,
        step && !primed_reg, primed_reg && beep_count_reg == $past(beep_count_reg),
        "priming item changed the queue")

endmodule

// File: hw/rtl/edge_count_beep_sequencer.sv
// ----------------------------------------------------------------------------
// edge_count_beep_sequencer
// buzzer sequencer that queues beeps on status flag edges
// ----------------------------------------------------------------------------
// Takes one item per clock with no bubbles while out_ready is held high.
// An accepted item lands in an input register; when the result register is
// free or draining, the core updates the flag, queue and stage state in one
// pass and loads the result register, which presents the result. The only
// loop is the state update in ecbs_core (edge count, saturating add, 32-bit
// timestamp subtract and compare). The result register decouples the sides:
// items keep coming in as long as a pending result is being taken or the
// register is empty. The user must write the on and off times through the
// apb port only while no item is in flight; the block does not enforce it.
module edge_count_beep_sequencer
    import ecbs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [TIME_W-1:0]   now_ms,
    input  logic                flag_catch,
    input  logic                flag_outpost,
    input  logic                flag_engineer,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                buzzer_on,
    output logic [COUNT_W-1:0]  pending_beeps,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

`include "edge_count_beep_sequencer_assert.svh"

    cfg_t    cfg;
    logic    s1_vld_reg;
    item_t   s1_item_reg;
    logic    out_vld_reg;
    result_t out_res_reg;
    result_t core_res;
    logic    advance;

    // stage 1 moves forward when the result register is free or draining
    assign advance  = !out_vld_reg || out_ready;
    assign in_ready = !s1_vld_reg || advance;

    ecbs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    ecbs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (s1_vld_reg && advance),
        .item   (s1_item_reg),
        .result (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= s1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg.now_ms <= now_ms;
            s1_item_reg.flags  <= {flag_engineer, flag_outpost, flag_catch};
        end
        if (s1_vld_reg && advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign out_valid     = out_vld_reg;
    assign buzzer_on     = out_res_reg.buzzer_on;
    assign pending_beeps = out_res_reg.pending_beeps;
    assign pready        = 1'b1;

    // a held item always reaches the result register once it is free
    `ECBS_ASSERT_NEXT(a_item_moves, s1_vld_reg && !out_vld_reg, out_vld_reg, "held item did not advance")

endmodule
